[hw/rtl/sfp_pkg.sv]
// Shared types and constants of the serial frame parser.
package sfp_pkg;

    localparam logic [7:0] HDR_BYTE0 = 8'h55;
    localparam logic [7:0] HDR_BYTE1 = 8'hAA;

    localparam logic [7:0] CMD_PING    = 8'h00;
    localparam logic [7:0] CMD_PRODUCT = 8'h01;
    localparam logic [7:0] CMD_FW_VER  = 8'h02;
    localparam logic [7:0] CMD_WIFI    = 8'h03;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    localparam logic [1:0] REPLY_NONE      = 2'd0;
    localparam logic [1:0] REPLY_HEARTBEAT = 2'd1;
    localparam logic [1:0] REPLY_PRODUCT   = 2'd2;
    localparam logic [1:0] REPLY_MCU_VER   = 2'd3;

    // Event passed from the parser front to the reply back end.
    typedef struct packed {
        logic        is_chk;   // checksum byte event, else payload byte
        logic        chk_ok;
        logic [7:0]  data;     // payload byte, or first payload byte at checksum
        logic [15:0] index;
        logic [7:0]  command;
        logic [7:0]  version;
        logic [15:0] length;
    } t_tok;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  command;
        logic [7:0]  version;
        logic [15:0] frame_length;
        logic [1:0]  reply_kind;
        logic        heartbeat_reply;
        logic [7:0]  wifi_status;
    } t_res;

endpackage

[hw/rtl/sfp_front.sv]
// Frame parser front: header hunt, field capture, running checksum, event generation.
module sfp_front
    import sfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_tok_valid,
    output t_tok       o_tok
);

    typedef enum logic [7:0] {
        PH_HDR1 = 8'b0000_0001,
        PH_HDR2 = 8'b0000_0010,
        PH_VER  = 8'b0000_0100,
        PH_CMD  = 8'b0000_1000,
        PH_LENH = 8'b0001_0000,
        PH_LENL = 8'b0010_0000,
        PH_DATA = 8'b0100_0000,
        PH_CHK  = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_ver, n_ver;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_rcvd, n_rcvd;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_first, n_first;
    logic [15:0] rcvd_inc;

    assign rcvd_inc = r_rcvd + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_ver       = r_ver;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_rcvd      = r_rcvd;
        n_sum       = r_sum;
        n_first     = r_first;
        o_tok_valid = 1'b0;
        o_tok       = '{is_chk: 1'b0, chk_ok: 1'b0, data: i_byte, index: r_rcvd,
                        command: r_cmd, version: r_ver, length: r_len};
        if (i_accept) begin
            case (r_phase)
                PH_HDR1: begin
                    n_phase = (i_byte == HDR_BYTE0) ? PH_HDR2 : PH_HDR1;
                end
                PH_HDR2: begin
                    n_phase = (i_byte == HDR_BYTE1) ? PH_VER : PH_HDR1;
                end
                PH_VER: begin
                    n_ver   = i_byte;
                    n_sum   = i_byte;
                    n_phase = PH_CMD;
                end
                PH_CMD: begin
                    n_cmd   = i_byte;
                    n_sum   = r_sum + i_byte;
                    n_phase = PH_LENH;
                end
                PH_LENH: begin
                    n_len   = {i_byte, 8'h00};
                    n_sum   = r_sum + i_byte;
                    n_phase = PH_LENL;
                end
                PH_LENL: begin
                    n_len   = {r_len[15:8], i_byte};
                    n_sum   = r_sum + i_byte;
                    n_rcvd  = '0;
                    n_first = '0;
                    n_phase = ({r_len[15:8], i_byte} != 16'd0) ? PH_DATA : PH_CHK;
                end
                PH_DATA: begin
                    if (r_rcvd == 16'd0) begin
                        n_first = i_byte;
                    end
                    n_sum       = r_sum + i_byte;
                    n_rcvd      = rcvd_inc;
                    n_phase     = (rcvd_inc >= r_len) ? PH_CHK : PH_DATA;
                    o_tok_valid = 1'b1;
                end
                PH_CHK: begin
                    n_phase      = PH_HDR1;
                    o_tok_valid  = 1'b1;
                    o_tok.is_chk = 1'b1;
                    o_tok.chk_ok = (i_byte == r_sum);
                    o_tok.data   = r_first;
                end
                default: begin
                    n_phase = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR1;
            r_ver   <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_rcvd  <= '0;
            r_sum   <= '0;
            r_first <= '0;
        end else begin
            r_phase <= n_phase;
            r_ver   <= n_ver;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_rcvd  <= n_rcvd;
            r_sum   <= n_sum;
            r_first <= n_first;
        end
    end

endmodule

[hw/rtl/sfp_queue.sv]
// Small register queue of parser events between front and back.
module sfp_queue
    import sfp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_tok i_wr_data,
    output logic o_full,
    input  logic i_rd,
    output t_tok o_rd_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_tok             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/sfp_back.sv]
// Reply back end: checksum verdict, reply selection, status update, output register.
module sfp_back
    import sfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_tok i_tok,
    output logic o_q_rd,
    input  logic i_pop,
    output logic o_valid,
    output t_res o_res
);

    logic       r_valid;
    t_res       r_res, n_res;
    logic       r_hb_seen, n_hb_seen;
    logic [7:0] r_wifi, n_wifi;
    logic       take;

    // Refill the output word when it is empty or leaving this cycle.
    assign take    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd  = take;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_hb_seen = r_hb_seen;
        n_wifi    = r_wifi;
        n_res     = '{kind: KIND_PAYLOAD, payload_byte: 8'h00, payload_index: 16'h0000,
                      command: i_tok.command, version: i_tok.version,
                      frame_length: i_tok.length, reply_kind: REPLY_NONE,
                      heartbeat_reply: 1'b0, wifi_status: r_wifi};
        if (!i_tok.is_chk) begin
            n_res.payload_byte  = i_tok.data;
            n_res.payload_index = i_tok.index;
        end else if (!i_tok.chk_ok) begin
            n_res.kind = KIND_BAD;
        end else begin
            n_res.kind = KIND_GOOD;
            case (i_tok.command)
                CMD_PING: begin
                    n_res.reply_kind      = REPLY_HEARTBEAT;
                    n_res.heartbeat_reply = r_hb_seen;
                    n_hb_seen             = 1'b1;
                end
                CMD_PRODUCT: n_res.reply_kind = REPLY_PRODUCT;
                CMD_FW_VER: n_res.reply_kind = REPLY_MCU_VER;
                CMD_WIFI: begin
                    if (i_tok.length != 16'd0) begin
                        n_wifi = i_tok.data;
                    end
                end
                default: n_res.reply_kind = REPLY_NONE;
            endcase
            n_res.wifi_status = n_wifi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_hb_seen <= 1'b0;
            r_wifi    <= '0;
        end else begin
            if (take) begin
                r_valid   <= 1'b1;
                r_hb_seen <= n_hb_seen;
                r_wifi    <= n_wifi;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/serial_frame_parser_sum_checksum.sv]
// Serial frame parser with 8-bit sum checksum (header 0x55 0xAA, version, command,
// 16-bit big-endian length, payload, checksum). One received byte is taken per clock
// whenever o_full is low; o_full rises only when the event queue between the parser
// front and the reply back end holds QUEUE_DEPTH events because results are not
// popped. Bytes that produce a result (payload bytes and the checksum byte) are
// registered in the event queue and then in the output register before they show on
// the result ports, and results can be popped one per clock while events wait in the
// queue. Each payload byte yields one word with its index; the checksum byte yields
// frame-good (with the reply to send) or checksum-mismatch. No clearing pass is needed after reset.
module serial_frame_parser_sum_checksum
    import sfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_rx_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_command,
    output logic [7:0]  o_version,
    output logic [15:0] o_frame_length,
    output logic [1:0]  o_reply_kind,
    output logic        o_heartbeat_reply,
    output logic [7:0]  o_wifi_status
);

    logic accept;
    logic tok_valid;
    t_tok tok_in, tok_out;
    logic q_empty, q_rd;
    logic out_valid;
    t_res res;

    assign accept = i_push && !o_full;

    sfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_rx_byte),
        .o_tok_valid(tok_valid),
        .o_tok      (tok_in)
    );

    sfp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tok_valid),
        .i_wr_data(tok_in),
        .o_full   (o_full),
        .i_rd     (q_rd),
        .o_rd_data(tok_out),
        .o_empty  (q_empty)
    );

    sfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_tok    (tok_out),
        .o_q_rd   (q_rd),
        .i_pop    (i_pop),
        .o_valid  (out_valid),
        .o_res    (res)
    );

    assign o_empty           = !out_valid;
    assign o_kind            = res.kind;
    assign o_payload_byte    = res.payload_byte;
    assign o_payload_index   = res.payload_index;
    assign o_command         = res.command;
    assign o_version         = res.version;
    assign o_frame_length    = res.frame_length;
    assign o_reply_kind      = res.reply_kind;
    assign o_heartbeat_reply = res.heartbeat_reply;
    assign o_wifi_status     = res.wifi_status;

endmodule

[hw/rtl/sfp_checker.sv]
// Port-level checks on the serial frame parser, bound to its top level.
module sfp_checker
    import sfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [15:0] o_payload_index,
    input logic [1:0]  o_reply_kind,
    input logic        o_heartbeat_reply
);

    // Only the three result kinds exist.
    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_kind == KIND_PAYLOAD || o_kind == KIND_GOOD || o_kind == KIND_BAD))
        else $error("result kind out of range");

    // A reply is only requested on a good frame.
    a_reply_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_reply_kind != REPLY_NONE) |-> (o_kind == KIND_GOOD))
        else $error("reply requested on a result that is not frame-good");

    // Heartbeat data is set only on a heartbeat reply.
    a_hb_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_heartbeat_reply) |-> (o_reply_kind == REPLY_HEARTBEAT))
        else $error("heartbeat data on a non-heartbeat result");

    // A waiting result holds while not popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_kind)
            && $stable(o_payload_byte) && $stable(o_payload_index)))
        else $error("waiting result changed before pop");

endmodule

bind serial_frame_parser_sum_checksum sfp_checker u_sfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_empty          (o_empty),
    .i_pop            (i_pop),
    .o_kind           (o_kind),
    .o_payload_byte   (o_payload_byte),
    .o_payload_index  (o_payload_index),
    .o_reply_kind     (o_reply_kind),
    .o_heartbeat_reply(o_heartbeat_reply)
);
